>>> rtl/kcc_pkg.sv
// Shared types, key codes and widths for the keypad calculator controller.
package kcc_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
    localparam int RES_W      = 16;
    localparam int KEY_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);
    localparam int OUT_BITS   = 28;
    localparam int OUT_TDATA  = 32;

    localparam logic [KEY_W-1:0] KEY_NONE    = 8'h3F;
    localparam logic [KEY_W-1:0] KEY_RESTART = 8'h40;
    localparam logic [KEY_W-1:0] KEY_EQUALS  = 8'h3D;
    localparam logic [KEY_W-1:0] KEY_ZERO    = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE    = 8'h39;
    localparam logic [KEY_W-1:0] KEY_PLUS    = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_MINUS   = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_TIMES   = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_DIVIDE  = 8'h2F;

    typedef enum logic [2:0] {
        K_NONE,
        K_RESTART,
        K_DIGIT,
        K_OPER,
        K_EQUALS,
        K_OTHER
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_kind              kind;
        t_op                op;
        logic [DIGIT_W-1:0] digit;
        logic [KEY_W-1:0]   key;
    } t_cmd;

    // first member sits in the high bits: echo_valid ends up at bit 0
    typedef struct packed {
        logic               clear_screen;
        logic               div_zero;
        logic [RES_W-1:0]   result_value;
        logic               result_valid;
        logic [KEY_W-1:0]   echo_char;
        logic               echo_valid;
    } t_res;

endpackage

>>> rtl/kcc_front.sv
// Front end: takes key requests and classifies them into commands for the queue.
module kcc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [kcc_pkg::KEY_W-1:0]   i_s_axis_tdata,   // [7:0] key
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output kcc_pkg::t_cmd               o_q_data
);

    kcc_pkg::t_cmd cmd;
    logic          r_seen;

    always_comb begin
        cmd       = '0;
        cmd.key   = i_s_axis_tdata;
        cmd.op    = kcc_pkg::OP_NONE;
        cmd.digit = '0;
        unique case (i_s_axis_tdata) inside
            kcc_pkg::KEY_NONE:    cmd.kind = kcc_pkg::K_NONE;
            kcc_pkg::KEY_RESTART: cmd.kind = kcc_pkg::K_RESTART;
            kcc_pkg::KEY_EQUALS:  cmd.kind = kcc_pkg::K_EQUALS;
            kcc_pkg::KEY_PLUS: begin
                cmd.kind = kcc_pkg::K_OPER;
                cmd.op   = kcc_pkg::OP_ADD;
            end
            kcc_pkg::KEY_MINUS: begin
                cmd.kind = kcc_pkg::K_OPER;
                cmd.op   = kcc_pkg::OP_SUB;
            end
            kcc_pkg::KEY_TIMES: begin
                cmd.kind = kcc_pkg::K_OPER;
                cmd.op   = kcc_pkg::OP_MUL;
            end
            kcc_pkg::KEY_DIVIDE: begin
                cmd.kind = kcc_pkg::K_OPER;
                cmd.op   = kcc_pkg::OP_DIV;
            end
            [kcc_pkg::KEY_ZERO:kcc_pkg::KEY_NINE]: begin
                cmd.kind  = kcc_pkg::K_DIGIT;
                cmd.digit = kcc_pkg::DIGIT_W'(i_s_axis_tdata - kcc_pkg::KEY_ZERO);
            end
            default: cmd.kind = kcc_pkg::K_OTHER;
        endcase
    end

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;
    assign o_q_data        = cmd;

    // sticky flag for the first request after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_q_push) begin
            r_seen <= 1'b1;
        end
    end

    first_push_after_reset_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && !r_seen) |=> r_seen)
        else $error("front: first request flag not set");

endmodule

>>> rtl/kcc_queue.sv
// Short command queue between the front end and the execution back end.
module kcc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kcc_pkg::t_cmd   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output kcc_pkg::t_cmd   o_data
);

    kcc_pkg::t_cmd              r_mem [kcc_pkg::QDEPTH];
    logic [kcc_pkg::QAW-1:0]    r_wptr;
    logic [kcc_pkg::QAW-1:0]    r_rptr;
    logic [kcc_pkg::QCW-1:0]    r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_full  = (r_count == kcc_pkg::QCW'(kcc_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/kcc_back.sv
// Back end: calculator state, arithmetic, iterative divider and output register.
module kcc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  kcc_pkg::t_cmd                   i_q_data,
    output logic                            o_q_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [kcc_pkg::OUT_TDATA-1:0]   o_m_axis_tdata
);

    localparam int W = kcc_pkg::DATA_WIDTH;

    kcc_pkg::t_state            r_state, n_state;
    logic [W-1:0]               r_first, n_first;
    logic [W-1:0]               r_second, n_second;
    kcc_pkg::t_op               r_op, n_op;
    logic                       r_awaiting, n_awaiting;
    logic [W-1:0]               r_rem, n_rem;
    logic [W-1:0]               r_quo, n_quo;
    logic [W-1:0]               r_dvs, n_dvs;
    logic                       r_neg, n_neg;
    logic [kcc_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    kcc_pkg::t_res              r_out, n_out;
    logic                       r_out_valid;
    logic                       out_we;
    logic                       out_free;
    logic [W:0]                 rem_sh;
    logic [2*W-1:0]             prod;
    logic [W-1:0]               quo_signed;

    function automatic logic [W-1:0] mac10(logic [W-1:0] x, logic [kcc_pkg::DIGIT_W-1:0] d);
        return (x << 3) + (x << 1) + W'(d);
    endfunction

    function automatic logic [kcc_pkg::RES_W-1:0] to_res(logic [W-1:0] v);
        logic signed [31:0] t;
        t = 32'(signed'(v));
        return t[kcc_pkg::RES_W-1:0];
    endfunction

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign rem_sh     = {r_rem, r_quo[W-1]};
    assign prod       = (2*W)'(signed'(r_first) * signed'(r_second));
    assign quo_signed = r_neg ? (W'(0) - r_quo) : r_quo;

    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        n_second   = r_second;
        n_op       = r_op;
        n_awaiting = r_awaiting;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dvs      = r_dvs;
        n_neg      = r_neg;
        n_cnt      = r_cnt;
        n_out      = r_out;
        out_we     = 1'b0;
        o_q_pop    = 1'b0;
        unique case (r_state)
            kcc_pkg::ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    out_we  = 1'b1;
                    n_out   = '0;
                    if (i_q_data.kind == kcc_pkg::K_NONE) begin
                        n_out = '0;
                    end else if (r_awaiting) begin
                        if (i_q_data.kind == kcc_pkg::K_RESTART) begin
                            n_first            = '0;
                            n_second           = '0;
                            n_op               = kcc_pkg::OP_NONE;
                            n_awaiting         = 1'b0;
                            n_out.clear_screen = 1'b1;
                        end
                    end else begin
                        n_out.echo_valid = 1'b1;
                        n_out.echo_char  = i_q_data.key;
                        unique case (i_q_data.kind)
                            kcc_pkg::K_OPER: n_op = i_q_data.op;
                            kcc_pkg::K_DIGIT: begin
                                if (r_op == kcc_pkg::OP_NONE) begin
                                    n_first = mac10(r_first, i_q_data.digit);
                                end else begin
                                    n_second = mac10(r_second, i_q_data.digit);
                                end
                            end
                            kcc_pkg::K_EQUALS: begin
                                n_awaiting         = 1'b1;
                                n_out.result_valid = 1'b1;
                                unique case (r_op)
                                    kcc_pkg::OP_ADD:
                                        n_out.result_value = to_res(r_first + r_second);
                                    kcc_pkg::OP_SUB:
                                        n_out.result_value = to_res(r_first - r_second);
                                    kcc_pkg::OP_MUL:
                                        n_out.result_value = to_res(prod[W-1:0]);
                                    kcc_pkg::OP_DIV: begin
                                        if (r_second == '0) begin
                                            n_out.div_zero = 1'b1;
                                        end else begin
                                            out_we  = 1'b0;
                                            n_out   = r_out;
                                            n_rem   = '0;
                                            n_quo   = r_first[W-1] ? (W'(0) - r_first)
                                                                   : r_first;
                                            n_dvs   = r_second[W-1] ? (W'(0) - r_second)
                                                                    : r_second;
                                            n_neg   = r_first[W-1] ^ r_second[W-1];
                                            n_cnt   = kcc_pkg::CNT_W'(W);
                                            n_state = kcc_pkg::ST_DIV;
                                        end
                                    end
                                    default: n_out.result_value = '0;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
            end
            kcc_pkg::ST_DIV: begin
                if (rem_sh >= {1'b0, r_dvs}) begin
                    n_rem = W'(rem_sh - {1'b0, r_dvs});
                    n_quo = {r_quo[W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[W-1:0];
                    n_quo = {r_quo[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == kcc_pkg::CNT_W'(1)) begin
                    n_state = kcc_pkg::ST_FIN;
                end
            end
            kcc_pkg::ST_FIN: begin
                if (out_free) begin
                    out_we             = 1'b1;
                    n_out              = '0;
                    n_out.echo_valid   = 1'b1;
                    n_out.echo_char    = kcc_pkg::KEY_EQUALS;
                    n_out.result_valid = 1'b1;
                    n_out.result_value = to_res(quo_signed);
                    n_state            = kcc_pkg::ST_IDLE;
                end
            end
            default: n_state = kcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kcc_pkg::ST_IDLE;
            r_first     <= '0;
            r_second    <= '0;
            r_op        <= kcc_pkg::OP_NONE;
            r_awaiting  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_second    <= n_second;
            r_op        <= n_op;
            r_awaiting  <= n_awaiting;
            r_out_valid <= out_we || (r_out_valid && !i_m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (out_we) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(kcc_pkg::OUT_TDATA - kcc_pkg::OUT_BITS)'(0), r_out};

    no_pop_while_dividing_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kcc_pkg::ST_IDLE) |-> !o_q_pop)
        else $error("back: queue popped while divider busy");

    divide_only_for_div_op_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kcc_pkg::ST_IDLE) |-> (r_op == kcc_pkg::OP_DIV && r_awaiting))
        else $error("back: divider running without a stored divide");

    no_echo_while_waiting_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_we && r_awaiting && r_state == kcc_pkg::ST_IDLE) |-> !n_out.echo_valid)
        else $error("back: key echoed while waiting for restart");

    div_zero_gives_zero_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.div_zero) |-> (r_out.result_valid && r_out.result_value == '0))
        else $error("back: division by zero with nonzero result");

    clear_resets_state_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_we && n_out.clear_screen) |=>
            (r_first == '0 && r_second == '0 && r_op == kcc_pkg::OP_NONE && !r_awaiting))
        else $error("back: restart did not clear calculator state");

endmodule

>>> rtl/keypad_calculator_controller.sv
// Four-function keypad calculator controller: top level.
//
// Input stream: one request per key press, tdata[7:0] is the ASCII key code.
// Output stream: exactly one result request per key request, in order.
// '?' (no key) and keys ignored while waiting for restart give an all-zero result.
// The front end classifies keys into a two-entry queue; the back end holds the
// operands, the stored operator and the restart flag, and owns a registered output.
// A key request passes through the queue entry and then the output register; '=' with
// a nonzero divisor under a stored divide also runs the one-bit-per-cycle restoring
// divider (ST_DIV) and then ST_FIN before its result is written.
// One key per cycle when the output is taken every cycle, but the divider blocks
// the back end while it runs.
// Reset (synchronous, active low) clears operands, operator, restart flag, queue
// and output valid. When the receiver stalls, the output holds, the back end stops,
// the queue fills, and the input tready drops once two commands are pending.
module keypad_calculator_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [kcc_pkg::KEY_W-1:0]       i_s_axis_tdata,   // [7:0] key
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [9] result_valid, [25:10] result_value,
    // [26] div_zero, [27] clear_screen, [31:28] zero
    output logic [kcc_pkg::OUT_TDATA-1:0]   o_m_axis_tdata
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    kcc_pkg::t_cmd  q_wdata;
    kcc_pkg::t_cmd  q_rdata;

    kcc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_data        (q_wdata)
    );

    kcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    kcc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> tb/sv/kcc_checker.sv
// Checker for the keypad calculator: predicts each key's outcome and compares the output stream.
module kcc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    input  logic [kcc_pkg::KEY_W-1:0]     i_s_axis_tdata,   // [7:0] key
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [9] result_valid, [25:10] result_value,
    // [26] div_zero, [27] clear_screen, [31:28] zero
    input  logic [kcc_pkg::OUT_TDATA-1:0] i_m_axis_tdata,
    output int                            o_pending,
    output int                            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [kcc_pkg::DATA_WIDTH-1:0] lhs;
    logic [kcc_pkg::DATA_WIDTH-1:0] rhs;
    kcc_pkg::t_op                   oper;
    logic                           waiting;
    kcc_pkg::t_res                  outcome_q[$];
    int                             errors;

    initial begin
        lhs     = '0;
        rhs     = '0;
        oper    = kcc_pkg::OP_NONE;
        waiting = 1'b0;
        errors  = 0;
    end

    function automatic kcc_pkg::t_res press_key(input logic [kcc_pkg::KEY_W-1:0] key);
        kcc_pkg::t_res r;
        int            a;
        int            b;
        int            q;
        r = '0;
        if (key == kcc_pkg::KEY_NONE)
            return r;
        if (waiting) begin
            if (key == kcc_pkg::KEY_RESTART) begin
                lhs            = '0;
                rhs            = '0;
                oper           = kcc_pkg::OP_NONE;
                waiting        = 1'b0;
                r.clear_screen = 1'b1;
            end
            return r;
        end
        r.echo_valid = 1'b1;
        r.echo_char  = key;
        case (key)
            kcc_pkg::KEY_PLUS:   oper = kcc_pkg::OP_ADD;
            kcc_pkg::KEY_MINUS:  oper = kcc_pkg::OP_SUB;
            kcc_pkg::KEY_TIMES:  oper = kcc_pkg::OP_MUL;
            kcc_pkg::KEY_DIVIDE: oper = kcc_pkg::OP_DIV;
            kcc_pkg::KEY_EQUALS: begin
                a = int'(signed'(lhs));
                b = int'(signed'(rhs));
                q = 0;
                case (oper)
                    kcc_pkg::OP_ADD: q = a + b;
                    kcc_pkg::OP_SUB: q = a - b;
                    kcc_pkg::OP_MUL: q = a * b;
                    kcc_pkg::OP_DIV: begin
                        if (b == 0)
                            r.div_zero = 1'b1;
                        else
                            q = a / b;
                    end
                    default: q = 0;
                endcase
                r.result_valid = 1'b1;
                r.result_value = q[kcc_pkg::RES_W-1:0];
                waiting        = 1'b1;
            end
            default: begin
                if (key >= kcc_pkg::KEY_ZERO && key <= kcc_pkg::KEY_NINE) begin
                    if (oper == kcc_pkg::OP_NONE)
                        lhs = lhs * kcc_pkg::DATA_WIDTH'(10)
                            + kcc_pkg::DATA_WIDTH'(key - kcc_pkg::KEY_ZERO);
                    else
                        rhs = rhs * kcc_pkg::DATA_WIDTH'(10)
                            + kcc_pkg::DATA_WIDTH'(key - kcc_pkg::KEY_ZERO);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(input string field, input longint want, input longint got);
        $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        kcc_pkg::t_res got;
        kcc_pkg::t_res want;
        if (!i_rst_n) begin
            lhs     = '0;
            rhs     = '0;
            oper    = kcc_pkg::OP_NONE;
            waiting = 1'b0;
            outcome_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                outcome_q.push_back(press_key(i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = kcc_pkg::t_res'(i_m_axis_tdata[kcc_pkg::OUT_BITS-1:0]);
                if (outcome_q.size() == 0) begin
                    $display("%0t ns unexpected result: expected none, got %h", $time, got);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.echo_valid !== want.echo_valid)
                        report("echo_valid", want.echo_valid, got.echo_valid);
                    if (got.echo_char !== want.echo_char)
                        report("echo_char", want.echo_char, got.echo_char);
                    if (got.result_valid !== want.result_valid)
                        report("result_valid", want.result_valid, got.result_valid);
                    if (got.result_value !== want.result_value)
                        report("result_value", want.result_value, got.result_value);
                    if (got.div_zero !== want.div_zero)
                        report("div_zero", want.div_zero, got.div_zero);
                    if (got.clear_screen !== want.clear_screen)
                        report("clear_screen", want.clear_screen, got.clear_screen);
                end
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= errors;
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the keypad calculator test: clock, reset, key stimulus, flow control and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS = 1500;
    localparam int LIMIT = 400000;
    localparam int TAIL  = 40;
    localparam logic [kcc_pkg::KEY_W-1:0] OPER_KEYS [4] = '{
        kcc_pkg::KEY_PLUS, kcc_pkg::KEY_MINUS, kcc_pkg::KEY_TIMES, kcc_pkg::KEY_DIVIDE
    };

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          key_valid = 1'b0;
    logic                          key_ready;
    logic [kcc_pkg::KEY_W-1:0]     key_data  = '0;
    logic                          res_valid;
    logic                          res_ready = 1'b0;
    logic [kcc_pkg::OUT_TDATA-1:0] res_data;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int sent       = 0;
    int cycles     = 0;
    int pending;
    int fail_count;

    keypad_calculator_controller uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (key_valid),
        .o_s_axis_tready (key_ready),
        .i_s_axis_tdata  (key_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    kcc_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (key_valid),
        .i_s_axis_tready (key_ready),
        .i_s_axis_tdata  (key_data),
        .i_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .i_m_axis_tdata  (res_data),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off counted down here
    always @(posedge clk) begin
        if (stall_left > 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            res_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic press(input logic [kcc_pkg::KEY_W-1:0] k);
        while ($urandom_range(0, 99) < idle_pct) begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid <= 1'b1;
        key_data  <= k;
        do @(posedge clk); while (!key_ready);
        sent++;
    endtask

    task automatic drain();
        key_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic int digit_count();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 8);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_number(input int ndig);
        repeat (ndig) press(8'(kcc_pkg::KEY_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0)
                press(kcc_pkg::KEY_NONE);
            else
                press(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_expression();
        send_number(digit_count());
        if ($urandom_range(0, 9) != 0)
            press(OPER_KEYS[2'($urandom_range(0, 3))]);
        if ($urandom_range(0, 4) == 0)
            press(OPER_KEYS[2'($urandom_range(0, 3))]);
        send_number(digit_count());
        if ($urandom_range(0, 9) == 0)
            send_noise();
        press(kcc_pkg::KEY_EQUALS);
        repeat ($urandom_range(0, 2)) press(8'($urandom_range(0, 255)));
        press(kcc_pkg::KEY_RESTART);
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) press(s[i]);
    endtask

    initial begin
        int  target;
        bit  held;
        held = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // no key, field extremes, restart while not waiting, bare equals, ignored key, clear
        press(kcc_pkg::KEY_NONE);
        press(8'h00);
        press(8'hFF);
        press(kcc_pkg::KEY_RESTART);
        press(kcc_pkg::KEY_EQUALS);
        press(8'(kcc_pkg::KEY_ZERO + 5));
        press(kcc_pkg::KEY_RESTART);
        // divide by an empty (zero) second operand
        press(kcc_pkg::KEY_DIVIDE);
        press(kcc_pkg::KEY_EQUALS);
        press(kcc_pkg::KEY_RESTART);
        // most negative over minus one, with the operator replaced
        send_text("32768*/65535=@");
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 69; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 69; end
                default: begin idle_pct = 25; stall_pct <= 25; end
            endcase
            target = sent + ITEMS / 4;
            while (sent < target) begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_expression();
                if (phase == 0 && !held && sent > target - ITEMS / 8) begin
                    stall_left <= 300;
                    held = 1'b1;
                end
            end
            drain();
        end

        repeat (TAIL) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/kcc_pkg.sv
rtl/kcc_front.sv
rtl/kcc_queue.sv
rtl/kcc_back.sv
rtl/keypad_calculator_controller.sv
tb/sv/kcc_checker.sv
tb/sv/testbench.sv
